// ----- rtl/owpp_pkg.sv -----
// owpp_pkg: shared types, constants and helpers of the omnidirectional projector
// used by owpp_mulq28 and omni_world_to_pixel_project; no dependencies
package owpp_pkg;

	localparam int MAX_COEFFS = 16;
	localparam int CIW        = $clog2(MAX_COEFFS);
	localparam int ANG_STEPS  = 28;
	localparam int DIV_STEPS  = 29;

	// atan(2^-i) in q.28
	localparam logic signed [31:0] ANG_TAB [ANG_STEPS] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
		32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
		32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072, 32'sd65536,
		32'sd32768, 32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024,
		32'sd512, 32'sd256, 32'sd128, 32'sd64, 32'sd32, 32'sd16, 32'sd8,
		32'sd4, 32'sd2
	};

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	localparam logic [2:0] REG_CENTER_X   = 3'd0;
	localparam logic [2:0] REG_CENTER_Y   = 3'd1;
	localparam logic [2:0] REG_AFFINE_C   = 3'd2;
	localparam logic [2:0] REG_AFFINE_D   = 3'd3;
	localparam logic [2:0] REG_AFFINE_E   = 3'd4;
	localparam logic [2:0] REG_NUM_COEFFS = 3'd5;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         coeff_index;
		logic signed [47:0] coeff_value;
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
	} owpp_item_t;

	typedef struct packed {
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic               at_center;
	} owpp_result_t;

	typedef struct packed {
		logic               start;
		logic signed [47:0] a;
		logic signed [31:0] b;
	} owpp_mreq_t;

	typedef struct packed {
		logic               done;
		logic signed [53:0] res;
	} owpp_mrsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQX, ST_SQY, ST_SQRT, ST_CORDIC, ST_POLY, ST_DIVX, ST_DIVY,
		ST_MPX, ST_MPY, ST_MC, ST_MD, ST_ME, ST_OUT
	} owpp_state_t;

	function automatic logic [23:0] mag24(input logic signed [23:0] v);
		logic [23:0] r;
		r = v[23] ? 24'(-v) : 24'(v);
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
		logic signed [47:0] r;
		if (v[55:47] == {9{v[55]}})
			r = v[47:0];
		else
			r = v[55] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
		logic signed [23:0] r;
		if (v[35:23] == {13{v[35]}})
			r = v[23:0];
		else
			r = v[35] ? {1'b1, 23'b0} : {1'b0, {23{1'b1}}};
		return r;
	endfunction

endpackage

// ----- rtl/owpp_mulq28.sv -----
// owpp_mulq28: shared q.28 multiplier, 48 x 32 bit signed, rounded half away from zero
// two partial products over one 24 x 32 multiplier; depends on owpp_pkg
module owpp_mulq28 import owpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  owpp_mreq_t req,
	output owpp_mrsp_t rsp
);

	logic [47:0]        ma_q;
	logic [31:0]        mb_q;
	logic               neg_q;
	logic [55:0]        hi_q;
	logic               p1_q, p2_q, done_q;
	logic signed [53:0] res_q;

	logic [23:0]        mop;
	logic [55:0]        prod;
	logic [56:0]        low_sum;
	logic [52:0]        r;

	assign mop     = p1_q ? ma_q[47:24] : ma_q[23:0];
	assign prod    = {32'b0, mop} * {24'b0, mb_q};
	assign low_sum = {29'b0, hi_q[3:0], 24'b0} + {1'b0, prod} + 57'd134217728;
	assign r       = {1'b0, hi_q[55:4]} + {24'b0, low_sum[56:28]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q   <= 1'b0;
			p2_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			p1_q   <= req.start;
			p2_q   <= p1_q;
			done_q <= p2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q  <= req.a[47] ? 48'(-req.a) : 48'(req.a);
			mb_q  <= req.b[31] ? 32'(-req.b) : 32'(req.b);
			neg_q <= req.a[47] ^ req.b[31];
		end
		if (p1_q)
			hi_q <= prod;
		if (p2_q)
			res_q <= neg_q ? -$signed({1'b0, r}) : $signed({1'b0, r});
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

// ----- rtl/omni_world_to_pixel_project.sv -----
// Omnidirectional world-to-pixel projector. A write item stores one q20.28
// coefficient and gives no result. A project item with zero x and y returns
// the saturated centre. Any other project item runs a 32-step bit-serial
// square root, 28 CORDIC vectoring steps, two 29-step restoring divides for
// the unit direction and num_coeffs+4 products through one shared q.28
// multiplier. One item is in work at a time; a finished result waits in the
// output register while the next item is taken. Depends on owpp_pkg and
// owpp_mulq28.
module omni_world_to_pixel_project import owpp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  owpp_item_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output owpp_result_t result,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	owpp_state_t state_q, state_d;

	logic [23:0]        center_x_q, center_y_q;
	logic signed [31:0] affine_c_q, affine_d_q, affine_e_q;
	logic [4:0]         num_coeffs_q;

	logic signed [47:0] coeff_mem [MAX_COEFFS];
	logic signed [47:0] rd_q;
	logic [CIW-1:0]     rd_addr;

	logic signed [23:0] x_q, y_q, z_q;
	logic               ctr_q;
	logic [47:0]        acc_q;
	logic [63:0]        rem_q, res_q, bit_q;
	logic [31:0]        norm_q;
	logic signed [35:0] xv_q, yv_q;
	logic signed [31:0] ang_q;
	logic [4:0]         it_q;
	logic [CIW-1:0]     pidx_q, pidx_init;
	logic signed [47:0] rho_q, px_q, py_q;
	logic [31:0]        dr_q;
	logic [28:0]        qt_q;
	logic signed [31:0] ux_q, uy_q;
	logic signed [55:0] sumx_q, sumy_q;
	logic               mbusy_q;
	owpp_result_t       result_q;
	logic               result_valid_q;

	owpp_mreq_t         mreq;
	owpp_mrsp_t         mrsp;
	logic               mul_op, out_go;
	logic [23:0]        mx, my;
	logic [47:0]        mxsq, sqsum;
	logic [64:0]        trial;
	logic [63:0]        root_next;
	logic [32:0]        dtrial;
	logic               qbit;
	logic [28:0]        q_next;
	logic signed [55:0] mres56, rtx, rty;

	owpp_mulq28 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign item_ready   = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign mx     = mag24(x_q);
	assign my     = mag24(y_q);
	assign mxsq   = {24'b0, mx} * {24'b0, mx};
	assign sqsum  = acc_q + ({24'b0, my} * {24'b0, my});
	assign trial  = {1'b0, res_q} + {1'b0, bit_q};
	assign root_next = (res_q >> 1) + (({1'b0, rem_q} >= trial) ? bit_q : 64'd0);
	assign dtrial = {dr_q, 1'b0};
	assign qbit   = (dtrial >= {1'b0, norm_q});
	assign q_next = {qt_q[27:0], qbit};
	assign mres56 = {{2{mrsp.res[53]}}, mrsp.res};
	assign rtx    = sumx_q + 56'sd524288;
	assign rty    = sumy_q + 56'sd524288;
	assign rd_addr = (state_q == ST_CORDIC) ? pidx_q : pidx_q - 1'b1;

	always_comb begin
		if (num_coeffs_q == 5'd0)
			pidx_init = '0;
		else if (32'(num_coeffs_q) > MAX_COEFFS)
			pidx_init = CIW'(MAX_COEFFS - 1);
		else
			pidx_init = CIW'(num_coeffs_q - 5'd1);
	end

	always_comb begin
		state_d = state_q;
		mul_op  = 1'b0;
		out_go  = !result_valid_q || result_ready;
		mreq.a  = rho_q;
		mreq.b  = ang_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid && item.opcode == OP_PROJECT)
					state_d = (item.point_x == '0 && item.point_y == '0) ? ST_OUT : ST_SQX;
			end
			ST_SQX: state_d = ST_SQY;
			ST_SQY: state_d = ST_SQRT;
			ST_SQRT: begin
				if (bit_q[0])
					state_d = ST_CORDIC;
			end
			ST_CORDIC: begin
				if (it_q == 5'(ANG_STEPS - 1))
					state_d = ST_POLY;
			end
			ST_POLY: begin
				if (pidx_q == '0)
					state_d = ST_DIVX;
				else
					mul_op = 1'b1;
			end
			ST_DIVX: begin
				if (it_q == 5'(DIV_STEPS - 1))
					state_d = ST_DIVY;
			end
			ST_DIVY: begin
				if (it_q == 5'(DIV_STEPS - 1))
					state_d = ST_MPX;
			end
			ST_MPX: begin
				mul_op = 1'b1;
				mreq.b = ux_q;
				if (mrsp.done)
					state_d = ST_MPY;
			end
			ST_MPY: begin
				mul_op = 1'b1;
				mreq.b = uy_q;
				if (mrsp.done)
					state_d = ST_MC;
			end
			ST_MC: begin
				mul_op = 1'b1;
				mreq.a = px_q;
				mreq.b = affine_c_q;
				if (mrsp.done)
					state_d = ST_MD;
			end
			ST_MD: begin
				mul_op = 1'b1;
				mreq.a = py_q;
				mreq.b = affine_d_q;
				if (mrsp.done)
					state_d = ST_ME;
			end
			ST_ME: begin
				mul_op = 1'b1;
				mreq.a = px_q;
				mreq.b = affine_e_q;
				if (mrsp.done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_go)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		mreq.start = mul_op && !mbusy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= '0;
			center_y_q   <= '0;
			affine_c_q   <= 32'sh1000_0000;
			affine_d_q   <= '0;
			affine_e_q   <= '0;
			num_coeffs_q <= 5'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CENTER_X:   center_x_q   <= cfg_data[23:0];
				REG_CENTER_Y:   center_y_q   <= cfg_data[23:0];
				REG_AFFINE_C:   affine_c_q   <= cfg_data;
				REG_AFFINE_D:   affine_d_q   <= cfg_data;
				REG_AFFINE_E:   affine_e_q   <= cfg_data;
				REG_NUM_COEFFS: num_coeffs_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready && item.opcode == OP_WRITE
		    && 32'(item.coeff_index) < MAX_COEFFS)
			coeff_mem[CIW'(item.coeff_index)] <= item.coeff_value;
		rd_q <= coeff_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (mreq.start)
				mbusy_q <= 1'b1;
			else if (mrsp.done)
				mbusy_q <= 1'b0;
			if (state_q == ST_OUT && out_go)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q    <= item.point_x;
				y_q    <= item.point_y;
				z_q    <= item.point_z;
				ctr_q  <= (item.point_x == '0 && item.point_y == '0);
				pidx_q <= pidx_init;
			end
			ST_SQX: acc_q <= mxsq;
			ST_SQY: begin
				rem_q <= {sqsum, 16'b0};
				res_q <= '0;
				bit_q <= {2'b01, 62'b0};
			end
			ST_SQRT: begin
				// bit-serial root, one result bit a cycle
				if ({1'b0, rem_q} >= trial) begin
					rem_q <= 64'({1'b0, rem_q} - trial);
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					norm_q <= root_next[31:0];
					xv_q   <= {4'b0, root_next[31:0]};
					yv_q   <= {{4{z_q[23]}}, z_q, 8'b0};
					ang_q  <= '0;
					it_q   <= '0;
				end
			end
			ST_CORDIC: begin
				if (!yv_q[35]) begin
					xv_q  <= xv_q + (yv_q >>> it_q);
					yv_q  <= yv_q - (xv_q >>> it_q);
					ang_q <= ang_q + ANG_TAB[it_q];
				end else begin
					xv_q  <= xv_q - (yv_q >>> it_q);
					yv_q  <= yv_q + (xv_q >>> it_q);
					ang_q <= ang_q - ANG_TAB[it_q];
				end
				it_q <= it_q + 5'd1;
				if (it_q == 5'(ANG_STEPS - 1))
					rho_q <= rd_q;
			end
			ST_POLY: begin
				if (pidx_q == '0) begin
					dr_q <= {1'b0, mx, 7'b0};
					qt_q <= '0;
					it_q <= '0;
				end else if (mrsp.done) begin
					// horner step: rho * theta plus the next lower coefficient
					rho_q  <= sat48(mres56 + {{8{rd_q[47]}}, rd_q});
					pidx_q <= pidx_q - 1'b1;
				end
			end
			ST_DIVX, ST_DIVY: begin
				if (it_q == 5'(DIV_STEPS - 1)) begin
					if (state_q == ST_DIVX) begin
						ux_q <= x_q[23] ? -$signed({3'b0, q_next}) : $signed({3'b0, q_next});
						dr_q <= {1'b0, my, 7'b0};
						qt_q <= '0;
						it_q <= '0;
					end else begin
						uy_q <= y_q[23] ? -$signed({3'b0, q_next}) : $signed({3'b0, q_next});
					end
				end else begin
					dr_q <= qbit ? 32'(dtrial - {1'b0, norm_q}) : dtrial[31:0];
					qt_q <= q_next;
					it_q <= it_q + 5'd1;
				end
			end
			ST_MPX: if (mrsp.done) px_q <= sat48(mres56);
			ST_MPY: if (mrsp.done) py_q <= sat48(mres56);
			ST_MC:  if (mrsp.done) sumx_q <= mres56 + {12'b0, center_x_q, 20'b0};
			ST_MD:  if (mrsp.done) sumx_q <= sumx_q + mres56;
			ST_ME: begin
				if (mrsp.done)
					sumy_q <= mres56 + {{8{py_q[47]}}, py_q} + {12'b0, center_y_q, 20'b0};
			end
			ST_OUT: begin
				if (out_go) begin
					result_q.at_center <= ctr_q;
					if (ctr_q) begin
						result_q.out_x <= center_x_q[23] ? 24'h7FFFFF : center_x_q;
						result_q.out_y <= center_y_q[23] ? 24'h7FFFFF : center_y_q;
					end else begin
						result_q.out_x <= sat24(rtx[55:20]);
						result_q.out_y <= sat24(rty[55:20]);
					end
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_mul_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> mbusy_q)
		else $error("multiplier finished without a request in flight");

	a_idle_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !mbusy_q)
		else $error("ready while a product is still in flight");

	a_center_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.at_center) |-> (!result.out_x[23] && !result.out_y[23]))
		else $error("centre result not saturated to the positive range");

	a_start_on_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.start |=> (state_q == ST_POLY || state_q == ST_MPX || state_q == ST_MPY
		                || state_q == ST_MC || state_q == ST_MD || state_q == ST_ME))
		else $error("product requested outside a multiply step");
`endif

endmodule
